/* hw/rtl/i8te_pkg.sv */
// ----------------------------------------------------------------------------
// i8te_pkg
// Shared types, constants and helper functions of the timestamp converter.
// ----------------------------------------------------------------------------
package i8te_pkg;

  localparam logic [16:0] MagMax = 17'd99999;
  localparam logic [3:0] TzStart = 4'd11;
  localparam logic [14:0] Recip25 = 15'd20972;
  localparam logic [25:0] Recip5 = 26'd53687092;

  typedef struct packed {
    logic signed [17:0] y;
    logic signed [17:0] m;
    logic signed [17:0] d;
    logic signed [17:0] h;
    logic signed [17:0] mi;
    logic signed [17:0] s;
    logic signed [1:0] tzs;
    logic signed [17:0] tzh;
    logic signed [17:0] tzm;
    logic ok;
  } rec_t;

  typedef struct packed {
    logic start;
    logic [25:0] dividend;
    logic by400;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [25:0] quot;
  } div_rsp_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c inside {8'd32, [8'd9:8'd13]};
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return c inside {[8'd48:8'd57]};
  endfunction

  function automatic logic is_pm(input logic [7:0] c);
    return (c == 8'd43) || (c == 8'd45);
  endfunction

  function automatic logic [16:0] sat_acc(input logic [16:0] mag, input logic [7:0] c);
    logic [20:0] v;
    v = 21'(mag) * 21'd10 + 21'(c[3:0]);
    return (v > 21'(MagMax)) ? MagMax : v[16:0];
  endfunction

  function automatic logic signed [17:0] apply_sign(input logic neg, input logic [16:0] mag);
    logic signed [17:0] v;
    v = $signed({1'b0, mag});
    return neg ? -v : v;
  endfunction

endpackage

/* hw/rtl/i8te_front.sv */
// ----------------------------------------------------------------------------
// i8te_front
// Character parser: reads the date/time fields and the zone offset and hands
// a finished record to the queue on the last character.
// ----------------------------------------------------------------------------
module i8te_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         ch,
  input  logic               last,
  output logic               rec_wr,
  output i8te_pkg::rec_t     rec
);

  logic [3:0] char_pos, char_pos_next;
  logic [2:0] phase, phase_next;
  logic signed [17:0] vals [6];
  logic signed [17:0] vals_next [6];
  logic [2:0] done_cnt, done_cnt_next;
  logic num_act, num_act_next, sgn_seen, sgn_seen_next, num_neg, num_neg_next;
  logic [16:0] mag, mag_next;
  logic stopped, stopped_next;
  logic [1:0] tz_phase, tz_phase_next;
  logic signed [1:0] tz_sign, tz_sign_next;
  logic signed [17:0] tzh, tzh_next, tzm, tzm_next;
  logic tz_act, tz_act_next, tz_sseen, tz_sseen_next, tz_neg, tz_neg_next;
  logic [16:0] tz_mag, tz_mag_next;
  logic signed [17:0] fvals [6];
  logic [2:0] fdone;
  logic signed [17:0] ftzh, ftzm;

  always_comb begin
    char_pos_next = char_pos;
    phase_next = phase;
    vals_next = vals;
    done_cnt_next = done_cnt;
    num_act_next = num_act;
    sgn_seen_next = sgn_seen;
    num_neg_next = num_neg;
    mag_next = mag;
    stopped_next = stopped;
    if (!stopped) begin
      if (num_act) begin
        if (i8te_pkg::is_dig(ch)) begin
          mag_next = i8te_pkg::sat_acc(mag, ch);
        end else begin
          for (int i = 0; i < 6; i++) begin
            if (3'(i) == phase) vals_next[i] = i8te_pkg::apply_sign(num_neg, mag);
          end
          done_cnt_next = phase + 3'd1;
          num_act_next = 1'b0;
          num_neg_next = 1'b0;
          case (phase)
            3'd0, 3'd1, 3'd3, 3'd4: begin
              if (ch == ((phase < 3'd2) ? 8'd45 : 8'd58)) phase_next = phase + 3'd1;
              else stopped_next = 1'b1;
            end
            3'd2: begin
              if (ch == 8'd84 || i8te_pkg::is_ws(ch)) begin
                phase_next = 3'd3;
              end else if (i8te_pkg::is_pm(ch)) begin
                phase_next = 3'd3;
                sgn_seen_next = 1'b1;
                num_neg_next = (ch == 8'd45);
              end else begin
                stopped_next = 1'b1;
              end
            end
            default: stopped_next = 1'b1;
          endcase
        end
      end else if (sgn_seen) begin
        sgn_seen_next = 1'b0;
        if (i8te_pkg::is_dig(ch)) begin
          num_act_next = 1'b1;
          mag_next = 17'(ch[3:0]);
        end else begin
          stopped_next = 1'b1;
        end
      end else if (i8te_pkg::is_ws(ch)) begin
        stopped_next = 1'b0;
      end else if (i8te_pkg::is_pm(ch)) begin
        sgn_seen_next = 1'b1;
        num_neg_next = (ch == 8'd45);
      end else if (i8te_pkg::is_dig(ch)) begin
        num_act_next = 1'b1;
        mag_next = 17'(ch[3:0]);
      end else begin
        stopped_next = 1'b1;
      end
    end

    tz_phase_next = tz_phase;
    tz_sign_next = tz_sign;
    tzh_next = tzh;
    tzm_next = tzm;
    tz_act_next = tz_act;
    tz_sseen_next = tz_sseen;
    tz_neg_next = tz_neg;
    tz_mag_next = tz_mag;
    if (tz_phase == 2'd0) begin
      if (char_pos >= i8te_pkg::TzStart) begin
        if (ch == 8'd90) begin
          tz_sign_next = 2'sd0;
          tz_phase_next = 2'd3;
        end else if (i8te_pkg::is_pm(ch)) begin
          tz_sign_next = (ch == 8'd43) ? 2'sd1 : -2'sd1;
          tz_phase_next = 2'd1;
        end
      end
    end else if (tz_phase != 2'd3) begin
      if (tz_act) begin
        if (i8te_pkg::is_dig(ch)) begin
          tz_mag_next = i8te_pkg::sat_acc(tz_mag, ch);
        end else begin
          if (tz_phase == 2'd1) tzh_next = i8te_pkg::apply_sign(tz_neg, tz_mag);
          else tzm_next = i8te_pkg::apply_sign(tz_neg, tz_mag);
          tz_act_next = 1'b0;
          if (tz_phase == 2'd1 && ch == 8'd58) begin
            tz_phase_next = 2'd2;
            tz_neg_next = 1'b0;
          end else begin
            tz_phase_next = 2'd3;
          end
        end
      end else if (tz_sseen) begin
        tz_sseen_next = 1'b0;
        if (i8te_pkg::is_dig(ch)) begin
          tz_act_next = 1'b1;
          tz_mag_next = 17'(ch[3:0]);
        end else begin
          tz_phase_next = 2'd3;
        end
      end else if (i8te_pkg::is_ws(ch)) begin
        tz_sseen_next = 1'b0;
      end else if (i8te_pkg::is_pm(ch)) begin
        tz_sseen_next = 1'b1;
        tz_neg_next = (ch == 8'd45);
      end else if (i8te_pkg::is_dig(ch)) begin
        tz_act_next = 1'b1;
        tz_mag_next = 17'(ch[3:0]);
      end else begin
        tz_phase_next = 2'd3;
      end
    end
    if (char_pos < i8te_pkg::TzStart) char_pos_next = char_pos + 4'd1;

    fvals = vals_next;
    fdone = done_cnt_next;
    if (!stopped_next && num_act_next) begin
      for (int i = 0; i < 6; i++) begin
        if (3'(i) == phase_next) fvals[i] = i8te_pkg::apply_sign(num_neg_next, mag_next);
      end
      fdone = phase_next + 3'd1;
    end
    ftzh = tzh_next;
    ftzm = tzm_next;
    if ((tz_phase_next == 2'd1 || tz_phase_next == 2'd2) && tz_act_next) begin
      if (tz_phase_next == 2'd1) ftzh = i8te_pkg::apply_sign(tz_neg_next, tz_mag_next);
      else ftzm = i8te_pkg::apply_sign(tz_neg_next, tz_mag_next);
    end

    rec_wr = take && last;
    rec.y = fvals[0];
    rec.m = fvals[1];
    rec.d = fvals[2];
    rec.h = fvals[3];
    rec.mi = fvals[4];
    rec.s = fvals[5];
    rec.tzs = tz_sign_next;
    rec.tzh = ftzh;
    rec.tzm = ftzm;
    rec.ok = (fdone >= 3'd5);
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last)) begin
      char_pos <= '0;
      phase <= '0;
      for (int i = 0; i < 6; i++) vals[i] <= '0;
      done_cnt <= '0;
      num_act <= 1'b0;
      sgn_seen <= 1'b0;
      num_neg <= 1'b0;
      mag <= '0;
      stopped <= 1'b0;
      tz_phase <= '0;
      tz_sign <= '0;
      tzh <= '0;
      tzm <= '0;
      tz_act <= 1'b0;
      tz_sseen <= 1'b0;
      tz_neg <= 1'b0;
      tz_mag <= '0;
    end else if (take) begin
      char_pos <= char_pos_next;
      phase <= phase_next;
      vals <= vals_next;
      done_cnt <= done_cnt_next;
      num_act <= num_act_next;
      sgn_seen <= sgn_seen_next;
      num_neg <= num_neg_next;
      mag <= mag_next;
      stopped <= stopped_next;
      tz_phase <= tz_phase_next;
      tz_sign <= tz_sign_next;
      tzh <= tzh_next;
      tzm <= tzm_next;
      tz_act <= tz_act_next;
      tz_sseen <= tz_sseen_next;
      tz_neg <= tz_neg_next;
      tz_mag <= tz_mag_next;
    end
  end

endmodule

/* hw/rtl/i8te_queue.sv */
// ----------------------------------------------------------------------------
// i8te_queue
// Two-entry record queue between the parser and the arithmetic sequencer.
// ----------------------------------------------------------------------------
module i8te_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  i8te_pkg::rec_t     wdata,
  input  logic               rd,
  output i8te_pkg::rec_t     rdata,
  output logic               q_full,
  output logic               q_empty
);

  i8te_pkg::rec_t slots [2];
  logic wp, rp;
  logic [1:0] count;

  assign q_full = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign rdata = slots[rp];

  always_ff @(posedge clk) begin
    if (wr) slots[wp] <= wdata;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= '0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      count <= count + 2'(wr) - 2'(rd);
    end
  end

endmodule

/* hw/rtl/i8te_div.sv */
// ----------------------------------------------------------------------------
// i8te_div
// Unsigned division by 400 or by 5 through reciprocal multiplication, with
// the quotient registered in the cycle after the request.
// ----------------------------------------------------------------------------
// The by-400 path takes dividends below 2^18 and divides the dividend shifted
// right by four by 25. The by-5 path takes dividends below 2^26.
module i8te_div (
  input  logic                 clk,
  input  logic                 rst,
  input  i8te_pkg::div_req_t   req,
  output i8te_pkg::div_rsp_t   rsp
);

  logic [25:0] q;
  logic done;
  logic [28:0] prod400;
  logic [51:0] prod5;

  assign prod400 = 29'(req.dividend[17:4]) * 29'(i8te_pkg::Recip25);
  assign prod5 = 52'(req.dividend) * 52'(i8te_pkg::Recip5);
  assign rsp.done = done;
  assign rsp.quot = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req.start;
    end
    if (req.start) begin
      q <= req.by400 ? 26'(prod400[28:19]) : 26'(prod5[51:28]);
    end
  end

endmodule

/* hw/rtl/i8te_back.sv */
// ----------------------------------------------------------------------------
// i8te_back
// Arithmetic sequencer: turns a parsed record into epoch seconds through the
// days-from-civil rule and holds the result in an output register.
// ----------------------------------------------------------------------------
module i8te_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  i8te_pkg::rec_t       head,
  output logic                 q_pop,
  output logic signed [45:0]   epoch,
  output logic                 ok,
  output logic                 empty,
  input  logic                 pop
);

  typedef enum logic [3:0] {
    S_IDLE, S_MULT, S_WERA, S_YOE, S_WF, S_DOE, S_DAYS, S_SEC, S_TZ, S_FIN
  } state_t;

  state_t state;
  i8te_pkg::rec_t r;
  i8te_pkg::div_req_t dreq;
  i8te_pkg::div_rsp_t drsp;
  logic signed [17:0] yp, mp;
  logic signed [24:0] t;
  logic signed [9:0] era;
  logic [8:0] yoe;
  logic signed [23:0] doy;
  logic signed [24:0] doe;
  logic signed [27:0] days;
  logic signed [47:0] prod, acc, tzp;
  logic [1:0] c100;
  logic out_valid;
  logic fin_load;
  logic signed [47:0] res;

  assign empty = !out_valid;
  assign q_pop = (state == S_IDLE) && !q_empty;
  assign fin_load = (state == S_FIN) && (!out_valid || pop);
  assign c100 = (yoe >= 9'd300) ? 2'd3 : (yoe >= 9'd200) ? 2'd2 : (yoe >= 9'd100) ? 2'd1 : 2'd0;

  always_comb begin
    dreq.start = 1'b0;
    dreq.dividend = 26'(t + 25'sd0) + 26'd20971520;
    dreq.by400 = 1'b0;
    if (state == S_MULT) begin
      dreq.start = 1'b1;
      dreq.dividend = 26'(yp) + 26'd102400;
      dreq.by400 = 1'b1;
    end else if (state == S_YOE) begin
      dreq.start = 1'b1;
    end
    case (r.tzs)
      2'sd1: res = acc - tzp;
      -2'sd1: res = acc + tzp;
      default: res = acc;
    endcase
  end

  i8te_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid && !pop) || fin_load;
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            r <= head;
            yp <= head.y - ((head.m <= 18'sd2) ? 18'sd1 : 18'sd0);
            mp <= (head.m > 18'sd2) ? head.m - 18'sd3 : head.m + 18'sd9;
            state <= S_MULT;
          end
        end
        S_MULT: begin
          t <= 25'(mp) * 25'sd153 + 25'sd2;
          state <= S_WERA;
        end
        S_WERA: begin
          if (drsp.done) begin
            era <= 10'($signed({1'b0, drsp.quot}) - 27'sd256);
            state <= S_YOE;
          end
        end
        S_YOE: begin
          yoe <= 9'(20'(yp) - 20'(era) * 20'sd400);
          state <= S_WF;
        end
        S_WF: begin
          if (drsp.done) begin
            doy <= 24'($signed({1'b0, drsp.quot}) - 27'sd4194304) + 24'(r.d) - 24'sd1;
            state <= S_DOE;
          end
        end
        S_DOE: begin
          doe <= $signed({1'b0, 24'(yoe) * 24'd365 + 24'(yoe[8:2]) - 24'(c100)}) + 25'(doy);
          acc <= 48'(r.h) * 48'sd3600;
          state <= S_DAYS;
        end
        S_DAYS: begin
          days <= 28'(era) * 28'sd146097 + 28'(doe) - 28'sd719468;
          acc <= acc + 48'(r.mi) * 48'sd60;
          state <= S_SEC;
        end
        S_SEC: begin
          prod <= 48'(days) * 48'sd86400;
          acc <= acc + 48'(r.s);
          tzp <= 48'(r.tzh) * 48'sd3600;
          state <= S_TZ;
        end
        S_TZ: begin
          tzp <= tzp + 48'(r.tzm) * 48'sd60;
          acc <= acc + prod;
          state <= S_FIN;
        end
        S_FIN: begin
          if (fin_load) begin
            epoch <= r.ok ? res[45:0] : 46'sd0;
            ok <= r.ok;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/iso8601_timestamp_to_epoch.sv */
// ----------------------------------------------------------------------------
// iso8601_timestamp_to_epoch
// ISO-8601 timestamp string to UTC Unix epoch seconds.
// ----------------------------------------------------------------------------
// Characters are taken one per cycle whenever full is low; the parser keeps
// no gap between strings. On the last character the parsed record enters a
// two-entry queue, and a sequencer turns it into seconds through its states
// S_MULT to S_FIN before the result reaches the output register. The
// divisions by 400 and by 5 are reciprocal multiplications with a registered
// quotient. A result that waits in the output register holds the sequencer,
// and when both queue entries are waiting, full stays high until one is taken.
module iso8601_timestamp_to_epoch (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         ch,
  input  logic               last,
  input  logic               push,
  output logic               full,
  output logic signed [45:0] epoch,
  output logic               ok,
  output logic               empty,
  input  logic               pop
);

  logic take, rec_wr, q_pop, q_empty;
  i8te_pkg::rec_t rec, head;

  assign take = push && !full;

  i8te_front u_front (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .ch     (ch),
    .last   (last),
    .rec_wr (rec_wr),
    .rec    (rec)
  );

  i8te_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (rec_wr),
    .wdata   (rec),
    .rd      (q_pop),
    .rdata   (head),
    .q_full  (full),
    .q_empty (q_empty)
  );

  i8te_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .head    (head),
    .q_pop   (q_pop),
    .epoch   (epoch),
    .ok      (ok),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

/* test/iso8601_timestamp_to_epoch_checker.sv */
// ----------------------------------------------------------------------------
// iso8601_timestamp_to_epoch_checker
// Watches the character and result channels, predicts each epoch and compares.
// ----------------------------------------------------------------------------
module iso8601_timestamp_to_epoch_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         ch,
  input  logic               last,
  input  logic               push,
  input  logic               full,
  input  logic signed [45:0] epoch,
  input  logic               ok,
  input  logic               empty,
  input  logic               pop,
  output int                 errors,
  output int                 pending,
  output int                 strings_seen,
  output int                 good_stamps
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [45:0] epoch;
    logic               ok;
  } stamp_t;

  localparam int unsigned MagLimit = 99999;
  localparam int unsigned OffsetStart = 11;
  localparam logic [1:0] TzIdle = 2'd0;
  localparam logic [1:0] TzHours = 2'd1;
  localparam logic [1:0] TzMinutes = 2'd2;
  localparam logic [1:0] TzDone = 2'd3;

  stamp_t    stamp_q[$];
  int        pos, phase, done_cnt;
  longint    fields[6];
  bit        num_on, sgn_seen, num_neg, stopped;
  longint    mag;
  logic [1:0] tz_ph;
  longint    tz_sgn, tz_h, tz_m, tz_mag;
  bit        tz_on, tz_sgn_seen, tz_neg;

  function automatic bit is_space(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  function automatic longint grow(longint m, logic [7:0] c);
    longint v;
    v = m * 10 + longint'(c - 8'd48);
    return v > MagLimit ? MagLimit : v;
  endfunction

  function automatic longint fdiv5(longint x);
    return x >= 0 ? x / 5 : -((-x + 4) / 5);
  endfunction

  function automatic longint days_from_civil(longint y, longint m, longint d);
    longint era, yoe, mp, doy, doe;
    if (m <= 2) y = y - 1;
    era = (y >= 0 ? y : y - 399) / 400;
    yoe = y - era * 400;
    mp = m > 2 ? m - 3 : m + 9;
    doy = fdiv5(153 * mp + 2) + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  task automatic clear_parser();
    pos = 0; phase = 0; done_cnt = 0;
    foreach (fields[i]) fields[i] = 0;
    num_on = 0; sgn_seen = 0; num_neg = 0; mag = 0; stopped = 0;
    tz_ph = TzIdle; tz_sgn = 0; tz_h = 0; tz_m = 0;
    tz_on = 0; tz_sgn_seen = 0; tz_neg = 0; tz_mag = 0;
  endtask

  task automatic close_field();
    if (phase < 6) fields[phase] = num_neg ? -mag : mag;
    done_cnt = phase + 1;
    num_on = 0;
  endtask

  task automatic take_separator(logic [7:0] c);
    num_neg = 0;
    case (phase)
      0, 1: begin
        if (c == "-") phase++; else stopped = 1;
      end
      2: begin
        if (c == "T" || is_space(c)) begin
          phase = 3;
        end else if (c == "+" || c == "-") begin
          phase = 3; sgn_seen = 1; num_neg = (c == "-");
        end else begin
          stopped = 1;
        end
      end
      3, 4: begin
        if (c == ":") phase++; else stopped = 1;
      end
      default: stopped = 1;
    endcase
  endtask

  task automatic date_byte(logic [7:0] c);
    if (stopped) return;
    if (num_on) begin
      if (is_digit(c)) begin
        mag = grow(mag, c);
      end else begin
        close_field();
        take_separator(c);
      end
    end else if (sgn_seen) begin
      sgn_seen = 0;
      if (is_digit(c)) begin
        num_on = 1; mag = c - 8'd48;
      end else begin
        stopped = 1;
      end
    end else if (is_space(c)) begin
    end else if (c == "+" || c == "-") begin
      sgn_seen = 1; num_neg = (c == "-");
    end else if (is_digit(c)) begin
      num_on = 1; mag = c - 8'd48;
    end else begin
      stopped = 1;
    end
  endtask

  task automatic store_offset();
    longint v;
    v = tz_neg ? -tz_mag : tz_mag;
    if (tz_ph == TzHours) tz_h = v; else tz_m = v;
    tz_on = 0;
  endtask

  task automatic offset_byte(logic [7:0] c);
    if (tz_ph == TzDone) return;
    if (tz_ph == TzIdle) begin
      if (pos < OffsetStart) return;
      if (c == "Z") begin
        tz_sgn = 0; tz_ph = TzDone;
      end else if (c == "+" || c == "-") begin
        tz_sgn = (c == "+") ? 1 : -1; tz_ph = TzHours;
      end
    end else if (tz_on) begin
      if (is_digit(c)) begin
        tz_mag = grow(tz_mag, c);
      end else begin
        store_offset();
        if (tz_ph == TzHours && c == ":") begin
          tz_ph = TzMinutes; tz_neg = 0;
        end else begin
          tz_ph = TzDone;
        end
      end
    end else if (tz_sgn_seen) begin
      tz_sgn_seen = 0;
      if (is_digit(c)) begin
        tz_on = 1; tz_mag = c - 8'd48;
      end else begin
        tz_ph = TzDone;
      end
    end else if (is_space(c)) begin
    end else if (c == "+" || c == "-") begin
      tz_sgn_seen = 1; tz_neg = (c == "-");
    end else if (is_digit(c)) begin
      tz_on = 1; tz_mag = c - 8'd48;
    end else begin
      tz_ph = TzDone;
    end
  endtask

  task automatic take_char(logic [7:0] c, logic fin);
    stamp_t s;
    longint e;
    date_byte(c);
    offset_byte(c);
    if (pos < OffsetStart) pos++;
    if (!fin) return;
    if (!stopped && num_on) close_field();
    if ((tz_ph == TzHours || tz_ph == TzMinutes) && tz_on) store_offset();
    s.ok = done_cnt >= 5;
    e = 0;
    if (s.ok) begin
      e = days_from_civil(fields[0], fields[1], fields[2]) * 86400
        + fields[3] * 3600 + fields[4] * 60 + fields[5];
      e = e - tz_sgn * (tz_h * 3600 + tz_m * 60);
    end
    s.epoch = e[45:0];
    stamp_q.insert(stamp_q.size(), s);
    strings_seen++;
    if (s.ok) good_stamps++;
    clear_parser();
  endtask

  initial begin
    errors = 0; strings_seen = 0; good_stamps = 0; pending = 0;
    clear_parser();
  end

  always @(posedge clk) begin
    stamp_t want;
    if (rst) begin
      clear_parser();
    end else begin
      if (push && !full) take_char(ch, last);
      if (pop && !empty) begin
        if (stamp_q.size() == 0) begin
          $display("%0t: unexpected result beat epoch=%0d ok=%0b", $time, epoch, ok);
          errors++;
        end else begin
          want = stamp_q.pop_front();
          if (epoch !== want.epoch) begin
            $display("%0t: epoch expected %0d actual %0d", $time, want.epoch, epoch);
            errors++;
          end
          if (ok !== want.ok) begin
            $display("%0t: ok expected %0b actual %0b", $time, want.ok, ok);
            errors++;
          end
        end
      end
    end
    pending = stamp_q.size();
  end
endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Feeds timestamp strings, well-formed and broken, under random stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 5000;

  logic               clk = 0;
  logic               rst = 1;
  logic [7:0]         ch = 0;
  logic               last = 0;
  logic               push = 0;
  logic               pop = 0;
  logic               full, ok, empty;
  logic signed [45:0] epoch;
  int                 errors, pending, strings_seen, good_stamps;
  int                 push_idle = 0, pop_idle = 0, chars_sent = 0, quiet = 0;
  bit                 hold_off = 0;

  iso8601_timestamp_to_epoch DUT (.*);
  iso8601_timestamp_to_epoch_checker checker_i (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(negedge clk) pop <= !rst && ($urandom_range(99) >= pop_idle);

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] c, logic fin);
    @(negedge clk);
    while (!hold_off && $urandom_range(99) < push_idle) begin
      push <= 0;
      @(negedge clk);
    end
    ch <= c; last <= fin; push <= 1;
    @(posedge clk);
    while (full) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  function automatic string digits(int n, int w);
    string s;
    s = $sformatf("%0d", n);
    while (s.len() < w) s = {"0", s};
    return s;
  endfunction

  function automatic string wsp();
    bit [7:0] opts[6] = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
    string s;
    s = " ";
    s[0] = opts[$urandom_range(5)];
    return s;
  endfunction

  function automatic string num_field(int w);
    case ($urandom_range(9))
      0: return digits($urandom_range(999999), 1);
      1: return {"-", digits($urandom_range(99), 1)};
      2: return {"+", digits($urandom_range(99), 1)};
      3: return {wsp(), digits($urandom_range(99), w)};
      default: return digits($urandom_range(w == 4 ? 9999 : 99), w);
    endcase
  endfunction

  function automatic string good_stamp();
    string s, tz;
    s = {num_field(4), "-", num_field(2), "-", num_field(2)};
    s = {s, ($urandom_range(3) == 0) ? wsp() : "T", num_field(2), ":", num_field(2)};
    if ($urandom_range(1)) s = {s, ":", num_field(2)};
    case ($urandom_range(5))
      0: tz = "Z";
      1: tz = {"+", digits($urandom_range(14), 2), ":", digits($urandom_range(59), 2)};
      2: tz = {"-", digits($urandom_range(14), 2)};
      3: tz = {"-", digits($urandom_range(99), 2), ":", num_field(2)};
      4: tz = {"+", wsp(), "-", digits($urandom_range(999), 1)};
      default: tz = "";
    endcase
    return {s, tz};
  endfunction

  task automatic send_noise();
    int n;
    string s;
    n = $urandom_range(1, 20);
    s = good_stamp();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(2) == 0 || i >= s.len()) send_byte(8'($urandom_range(255)), i == n - 1);
      else send_byte(s[i], i == n - 1);
    end
  endtask

  task automatic drain();
    hold_off = 1;
    @(negedge clk);
    push <= 0;
    while (pending != 0) @(negedge clk);
    hold_off = 0;
  endtask

  initial begin
    string cases[$] = '{
      "1970-01-01T00:00:00Z", "2000-02-29T12:34:56+05:30", "1969-12-31 23:59:59-08",
      "99999999-99-99T99:99:99", "-0001-03-01T00:00", "  +2024-1-1\t-5:7:9",
      "0000-00-00T00:00:00+99:99", "2038-01-19T03:14:07.5Z", "2024-06-15T10:20+",
      "2024-06-15T10:20-:5", "2024-06-15", "2024/06/15T10:20", "2024-06-15x10:20",
      "2024-06-15T10:20:30:40", "2024-06-15T10:-", "Z", "1", "+-1999-1-1T1:1",
      "1600-02-28T24:60:60-00:00", "2100-03-01T00:00Z+01"};
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 0;
    foreach (cases[i]) send_text(cases[i]);
    send_byte(8'd255, 0); send_byte(8'd0, 0); send_byte(8'd128, 1);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      push_idle = (ph == 0) ? 35 : (ph == 1) ? 53 : 0;
      pop_idle = (ph == 0) ? 53 : (ph == 1) ? 35 : 0;
      while (chars_sent < 360 + 180 * (ph + 1)) begin
        if ($urandom_range(4) == 0) send_noise();
        else send_text(good_stamp());
      end
      drain();
    end
    repeat (200) @(posedge clk);
    $display("Sent %0d characters in %0d strings, %0d of them complete timestamps.",
             chars_sent, strings_seen, good_stamps);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
